>>> rtl/tprs_pkg.sv
// tprs_pkg: shared types, constants and helpers for the two-level thread scheduler
// used by tprs_ready_q and two_level_priority_rr_scheduler_core
// no dependencies
`default_nettype none

package tprs_pkg;

	// slot table geometry
	localparam int MAX_THREADS = 16;
	localparam int SLOT_W      = $clog2(MAX_THREADS);
	localparam int CNT_W       = $clog2(MAX_THREADS + 1);
	localparam int TICK_W      = 16;

	localparam logic [TICK_W-1:0] QUANTUM_RESET = TICK_W'(20);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TICK_W-1:0] tick_t;

	// transaction function codes
	typedef enum logic [1:0] {
		FUNC_CREATE   = 2'd0,
		FUNC_EXIT     = 2'd1,
		FUNC_TICK     = 2'd2,
		FUNC_SET_PRIO = 2'd3
	} func_t;

	// context switch reasons
	typedef enum logic [1:0] {
		SW_NONE    = 2'd0,
		SW_EXIT    = 2'd1,
		SW_PREEMPT = 2'd2,
		SW_ROTATE  = 2'd3
	} switch_t;

	// ready queue request from the control logic
	typedef struct packed {
		logic  push;
		logic  pop;
		slot_t slot;
	} q_req_t;

	// ready queue status back to the control logic
	typedef struct packed {
		cnt_t  count;
		slot_t head_slot;
	} q_stat_t;

	// result of the free-slot search
	typedef struct packed {
		logic  found;
		slot_t idx;
	} free_t;

	// lowest free slot, priority encoded
	function automatic free_t lowest_free(input logic [MAX_THREADS-1:0] busy);
		free_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = MAX_THREADS - 1; i >= 0; i--) begin
			if (!busy[i]) begin
				r.found = 1'b1;
				r.idx   = slot_t'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/tprs_ready_q.sv
// tprs_ready_q: one FIFO ready queue of slot numbers, with head, tail and count
// depends on tprs_pkg
// pushes to a full queue are dropped, pops from an empty one are ignored
`default_nettype none

module tprs_ready_q
	import tprs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_req_t  req,
	output q_stat_t      stat
);

	slot_t entry_q [MAX_THREADS];
	slot_t head_q;
	slot_t tail_q;
	cnt_t  count_q;

	logic push_en;
	logic pop_en;

	// a pop in the same cycle as a push into an empty queue takes the pushed slot
	assign push_en = req.push && (count_q != cnt_t'(MAX_THREADS));
	assign pop_en  = req.pop && ((count_q != '0) || push_en);

	assign stat.count     = count_q;
	assign stat.head_slot = entry_q[head_q];

	// entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_en) begin
			entry_q[tail_q] <= req.slot;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_en) begin
				tail_q <= (tail_q == slot_t'(MAX_THREADS - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop_en) begin
				head_q <= (head_q == slot_t'(MAX_THREADS - 1)) ? '0 : head_q + 1'b1;
			end
			if (push_en && !pop_en) begin
				count_q <= count_q + 1'b1;
			end else if (pop_en && !push_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_THREADS))
		else $error("ready queue count out of range");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty ready queue with unequal pointers");
	a_partial_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q != '0) && (count_q != cnt_t'(MAX_THREADS))) |-> (head_q != tail_q))
		else $error("partly filled ready queue with equal pointers");
`endif

endmodule

`default_nettype wire

>>> rtl/two_level_priority_rr_scheduler_core.sv
// two_level_priority_rr_scheduler_core: top level of the thread scheduler
// depends on tprs_pkg and tprs_ready_q
`default_nettype none

// One transaction enters per clock while the result side keeps up. The
// request is captured in an input register; when the result register is
// free, the slot table, both ready queues and the result register are
// updated from it in a single pass, and the result is presented from the
// result register. The longest path is the 16-slot free-slot priority
// encoder followed by the queue head select. A stalled result holds the
// input register, so throughput stays at one transaction per cycle while
// the result side keeps up. Slot 0 is running after reset. High-priority
// threads run until they exit or are set to low priority; low-priority
// threads rotate after the configured quantum of ticks (0 means 65536).
// Once the last thread exits with both queues empty, all_done is set and
// every later transaction returns the final state unchanged. The quantum
// should be written only while no transaction is in flight.

module two_level_priority_rr_scheduler_core
	import tprs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire tick_t       cfg_wdata,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic        priority_req,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output slot_t            running_thread,
	output slot_t            new_thread,
	output logic             create_ok,
	output logic [1:0]       switch_kind,
	output logic             running_priority,
	output logic             all_done
);

	// configuration and scheduler state
	tick_t                  quantum_q;
	logic [MAX_THREADS-1:0] slot_busy_q;
	logic [MAX_THREADS-1:0] slot_high_q;
	tick_t                  ticks_q [MAX_THREADS];
	slot_t                  cur_q;
	logic                   finished_q;

	// input register
	logic  valid_s1;
	func_t func_s1;
	logic  prio_s1;

	// result register
	logic  out_valid_q;
	slot_t running_q;
	slot_t new_thread_q;
	logic  create_ok_q;
	logic  [1:0] switch_kind_q;
	logic  running_prio_q;
	logic  all_done_q;

	// next-state terms
	logic                   adv;
	logic                   fire;
	logic                   do_item;
	logic [MAX_THREADS-1:0] busy_d;
	logic [MAX_THREADS-1:0] high_d;
	logic                   ticks_we;
	slot_t                  ticks_idx;
	tick_t                  ticks_val;
	tick_t                  ticks_dec;
	slot_t                  cur_d;
	logic                   fin_d;
	slot_t                  new_slot;
	logic                   ok;
	switch_t                kind;
	logic                   do_dispatch;
	logic                   old_free;
	logic                   old_high;
	logic                   cur_high;
	free_t                  free_slot;
	q_req_t                 h_req;
	q_req_t                 l_req;
	q_stat_t                h_stat;
	q_stat_t                l_stat;

	// handshake: result register frees or is taken, input register follows
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;
	assign do_item  = fire && !finished_q;

	assign cur_high  = slot_high_q[cur_q];
	assign ticks_dec = ticks_q[cur_q] - 1'b1;
	assign free_slot = lowest_free(slot_busy_q);

	// ready queues
	tprs_ready_q u_high_q (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (h_req),
		.stat   (h_stat)
	);

	tprs_ready_q u_low_q (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (l_req),
		.stat   (l_stat)
	);

	// single-pass transaction decode, queue moves and dispatch
	always_comb begin
		busy_d      = slot_busy_q;
		high_d      = slot_high_q;
		ticks_we    = 1'b0;
		ticks_idx   = cur_q;
		ticks_val   = quantum_q;
		cur_d       = cur_q;
		fin_d       = finished_q;
		new_slot    = '0;
		ok          = 1'b0;
		kind        = SW_NONE;
		do_dispatch = 1'b0;
		old_free    = 1'b0;
		old_high    = cur_high;
		h_req       = '0;
		l_req       = '0;

		if (do_item) begin
			unique case (func_s1)
				FUNC_CREATE: begin
					if (free_slot.found) begin
						busy_d[free_slot.idx] = 1'b1;
						high_d[free_slot.idx] = prio_s1;
						ticks_we              = 1'b1;
						ticks_idx             = free_slot.idx;
						ticks_val             = quantum_q;
						new_slot              = free_slot.idx;
						ok                    = 1'b1;
						if (prio_s1) begin
							h_req.push = 1'b1;
							h_req.slot = free_slot.idx;
						end else begin
							l_req.push = 1'b1;
							l_req.slot = free_slot.idx;
						end
						do_dispatch = prio_s1 && !cur_high;
					end
				end
				FUNC_EXIT: begin
					busy_d[cur_q] = 1'b0;
					old_free      = 1'b1;
					if ((h_stat.count != '0) || (l_stat.count != '0)) begin
						do_dispatch = 1'b1;
					end else begin
						fin_d = 1'b1;
					end
				end
				FUNC_TICK: begin
					if (!cur_high) begin
						ticks_we  = 1'b1;
						ticks_idx = cur_q;
						if (ticks_dec == '0) begin
							ticks_val   = quantum_q;
							do_dispatch = 1'b1;
						end else begin
							ticks_val = ticks_dec;
						end
					end
				end
				FUNC_SET_PRIO: begin
					high_d[cur_q] = prio_s1;
				end
				default: begin
				end
			endcase

			// dispatch: requeue a still-busy running thread, pick high before low
			if (do_dispatch) begin
				if (!old_free) begin
					if (old_high) begin
						h_req.push = 1'b1;
						h_req.slot = cur_q;
					end else begin
						l_req.push = 1'b1;
						l_req.slot = cur_q;
					end
				end
				if ((h_stat.count != '0) || h_req.push) begin
					h_req.pop = 1'b1;
					cur_d     = (h_stat.count == '0) ? h_req.slot : h_stat.head_slot;
				end else begin
					l_req.pop = 1'b1;
					cur_d     = (l_stat.count == '0) ? l_req.slot : l_stat.head_slot;
				end
				if (old_free) begin
					kind = SW_EXIT;
				end else if (!old_high && high_d[cur_d]) begin
					kind = SW_PREEMPT;
				end else begin
					kind = SW_ROTATE;
				end
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	// slot table and running thread
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_busy_q    <= '0;
			slot_busy_q[0] <= 1'b1;
			slot_high_q    <= '0;
			for (int i = 0; i < MAX_THREADS; i++) begin
				ticks_q[i] <= '0;
			end
			ticks_q[0]     <= QUANTUM_RESET;
			cur_q          <= '0;
			finished_q     <= 1'b0;
		end else if (do_item) begin
			slot_busy_q <= busy_d;
			slot_high_q <= high_d;
			if (ticks_we) begin
				ticks_q[ticks_idx] <= ticks_val;
			end
			cur_q      <= cur_d;
			finished_q <= fin_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			func_s1  <= FUNC_CREATE;
			prio_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				func_s1 <= func_t'(func);
				prio_s1 <= priority_req;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			running_q      <= cur_d;
			new_thread_q   <= new_slot;
			create_ok_q    <= ok;
			switch_kind_q  <= kind;
			running_prio_q <= high_d[cur_d];
			all_done_q     <= fin_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign running_thread   = running_q;
	assign new_thread       = new_thread_q;
	assign create_ok        = create_ok_q;
	assign switch_kind      = switch_kind_q;
	assign running_priority = running_prio_q;
	assign all_done         = all_done_q;

`ifndef SYNTHESIS
	a_running_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!finished_q |-> slot_busy_q[cur_q])
		else $error("running slot is not busy");
	a_thread_census: assert property (@(posedge clk) disable iff (!arst_n)
		!finished_q |-> ($countones(slot_busy_q) ==
			int'(h_stat.count) + int'(l_stat.count) + 1))
		else $error("busy slots do not match queued plus running threads");
	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("all-done flag cleared");
	a_high_not_rotated: assert property (@(posedge clk) disable iff (!arst_n)
		(do_item && (func_s1 == FUNC_TICK) && cur_high) |=> (cur_q == $past(cur_q)))
		else $error("tick switched away from a high-priority thread");
`endif

endmodule

`default_nettype wire
